FILE: rtl/mbps_pkg.sv
// Shared types, constants and helpers of the masked byte pattern scanner.
// Used by the configuration block, the window and compare stages and the top level.
package mbps_pkg;

	// Register indexes (byte address / 8)
	localparam logic [2:0] REG_PAT_A  = 3'd0;
	localparam logic [2:0] REG_PAT_B  = 3'd1;
	localparam logic [2:0] REG_PAT_C  = 3'd2;
	localparam logic [2:0] REG_PAT_D  = 3'd3;
	localparam logic [2:0] REG_CARE   = 3'd4;
	localparam logic [2:0] REG_LENGTH = 3'd5;

	localparam int unsigned ADDR_W    = 6;
	localparam int unsigned PAT_BYTES = 32;
	localparam int unsigned LEN_W     = 6;

	localparam logic [7:0]  NIB_LO    = 8'h0F;
	localparam logic [7:0]  NIB_HI    = 8'hF0;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Scan settings handed from the register block to the compare stage
	typedef struct packed {
		logic [PAT_BYTES*8-1:0] pattern;  // byte k at bits 8k
		logic [2*PAT_BYTES-1:0] care;     // two care bits per byte
		logic [LEN_W-1:0]       length;
	} scan_cfg_t;

	function automatic logic [7:0] pat_byte(input logic [PAT_BYTES*8-1:0] p,
	                                        input logic [4:0] k);
		return p[{k, 3'b000} +: 8];
	endfunction

	// Care mask of pattern byte k: a clear bit makes that nibble a wildcard
	function automatic logic [7:0] pat_mask(input logic [2*PAT_BYTES-1:0] c,
	                                        input logic [4:0] k);
		logic [7:0] m;
		m = 8'h00;
		if (c[{k, 1'b0}]) m = m | NIB_LO;
		if (c[{k, 1'b1}]) m = m | NIB_HI;
		return m;
	endfunction

endpackage

FILE: rtl/mbps_cfg_regs.sv
// APB register block of the scanner: pattern bytes, nibble care bits, length.
// Depends on mbps_pkg for register indexes and the settings struct.
module mbps_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mbps_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	output mbps_pkg::scan_cfg_t        cfg
);
	import mbps_pkg::*;

	logic [3:0][63:0] pat_q;
	logic [63:0]      care_q;
	logic [LEN_W-1:0] length_q;
	logic             wr_en;
	logic [2:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[5:3];

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q    <= '0;
			care_q   <= '0;
			length_q <= LEN_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_PAT_A:  pat_q[0] <= pwdata;
				REG_PAT_B:  pat_q[1] <= pwdata;
				REG_PAT_C:  pat_q[2] <= pwdata;
				REG_PAT_D:  pat_q[3] <= pwdata;
				REG_CARE:   care_q   <= pwdata;
				REG_LENGTH: length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_PAT_A:  prdata = pat_q[0];
			REG_PAT_B:  prdata = pat_q[1];
			REG_PAT_C:  prdata = pat_q[2];
			REG_PAT_D:  prdata = pat_q[3];
			REG_CARE:   prdata = care_q;
			REG_LENGTH: prdata = {{(64-LEN_W){1'b0}}, length_q};
			default:    prdata = 64'd0;
		endcase
	end

	assign cfg.pattern = pat_q;
	assign cfg.care    = care_q;
	assign cfg.length  = length_q;

endmodule

FILE: rtl/mbps_window.sv
// Input stage of the scanner: byte window shift line and segment byte count.
// Depends on mbps_pkg for the count limit.
module mbps_window #(
	parameter int unsigned MAX_PATTERN_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,       // request taken this cycle
	input  logic        in_ready,      // stage 1 may load
	input  logic        in_valid,
	input  logic [7:0]  data_byte,
	input  logic        segment_start,
	output logic        valid_s1,
	output logic [7:0]  window_q [MAX_PATTERN_BYTES],
	output logic [31:0] count_q
);
	import mbps_pkg::*;

	logic [31:0] count_base;

	assign count_base = segment_start ? 32'd0 : count_q;

	// Stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Window shift, newest byte at entry 0; segment start clears older bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) window_q[i] <= 8'h00;
			count_q <= 32'd0;
		end else if (in_fire) begin
			window_q[0] <= data_byte;
			for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
				window_q[i] <= segment_start ? 8'h00 : window_q[i-1];
			end
			if (count_base != COUNT_MAX) begin
				count_q <= count_base + 32'd1;
			end else begin
				count_q <= count_base;
			end
		end
	end

endmodule

FILE: rtl/mbps_match.sv
// Compare stage of the scanner: masked parallel compare and result register.
// Depends on mbps_pkg for the settings struct and pattern helpers.
module mbps_match #(
	parameter int unsigned MAX_PATTERN_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbps_pkg::scan_cfg_t cfg,
	input  logic                valid_s1,
	input  logic [7:0]          window_q [MAX_PATTERN_BYTES],
	input  logic [31:0]         count_q,
	input  logic                out_ready,
	output logic                advance,
	output logic                out_valid_s2,
	output logic [31:0]         out_offset_s2
);
	import mbps_pkg::*;

	localparam int unsigned IDX_W   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);

	logic [LEN_W-1:0] len_eff;
	logic             hit;
	logic [31:0]      offset;

	assign advance = !out_valid_s2 || out_ready;
	assign len_eff = (cfg.length > LEN_MAX) ? LEN_MAX : cfg.length;
	assign offset  = count_q - {{(32-LEN_W){1'b0}}, len_eff};

	// Pattern byte j lines up with window entry len-1-j
	always_comb begin
		logic [LEN_W-1:0] idx;
		logic [7:0]       m;
		logic             mism;
		hit = (len_eff != '0) && (count_q >= {{(32-LEN_W){1'b0}}, len_eff});
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			idx  = len_eff - LEN_W'(1) - LEN_W'(j);
			m    = pat_mask(cfg.care, 5'(j));
			mism = ((window_q[idx[IDX_W-1:0]] ^ pat_byte(cfg.pattern, 5'(j))) & m) != 8'h00;
			if ((LEN_W'(j) < len_eff) && mism) hit = 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && hit) begin
			out_offset_s2 <= offset;
		end
	end

endmodule

FILE: rtl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: top level joining registers, window and compare.
// Depends on mbps_pkg, mbps_cfg_regs, mbps_window and mbps_match.
//
// Takes one byte per clock and reports the segment offset of every match of a
// pattern of up to 32 bytes with per-nibble wildcards; matches may overlap.
// Each request passes the window stage, which shifts the byte into the window
// and counts it, then the compare stage, which does the masked compare of all
// pattern bytes in parallel into the result register. Both stages advance
// together, so a new byte is accepted every cycle while results are taken;
// when a result is held, one further byte is still accepted into the window
// stage. Registers are 64 bits wide at byte address 8*i; program them only
// while the stream is idle. The offset count saturates at 0xFFFFFFFF.
module masked_byte_pattern_scanner #(
	parameter int unsigned MAX_PATTERN_BYTES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbps_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] data_byte
	input  logic                        s_tuser,   // [0] segment_start
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata    // [31:0] match_offset
);
	import mbps_pkg::*;

	scan_cfg_t   cfg;
	logic        advance;
	logic        valid_s1;
	logic [7:0]  window_q [MAX_PATTERN_BYTES];
	logic [31:0] count_q;
	logic        in_fire;

	assign s_tready = !valid_s1 || advance;
	assign in_fire  = s_tvalid && s_tready;

	mbps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mbps_window #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.in_ready      (s_tready),
		.in_valid      (s_tvalid),
		.data_byte     (s_tdata),
		.segment_start (s_tuser),
		.valid_s1      (valid_s1),
		.window_q      (window_q),
		.count_q       (count_q)
	);

	mbps_match #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.window_q      (window_q),
		.count_q       (count_q),
		.out_ready     (m_tready),
		.advance       (advance),
		.out_valid_s2  (m_tvalid),
		.out_offset_s2 (m_tdata)
	);

endmodule

FILE: rtl/mbps_checker.sv
// Port-level checks of the masked byte pattern scanner, bound to the top level.
// Sees only the top-level stream ports.
module mbps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A held result keeps its offset
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An empty result register never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// A draining output lets bytes stream every cycle
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// A new result follows an accepted request through the window stage and the result register
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching request");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/masked_byte_pattern_scanner_checker.sv
// Scoreboard for the masked byte pattern scanner: mirrors register writes,
// predicts match offsets from accepted bytes and checks the result stream.
// Depends on mbps_pkg for widths and register indexes.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_checker
	import mbps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	input  logic              pready,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] segment_start
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [31:0]       m_tdata,   // [31:0] match_offset
	output int                fail_count,
	output int                pending,
	output int                bytes_scanned,
	output int                matches_checked
);

	// mirrored scan settings
	logic [PAT_BYTES*8-1:0] scan_pattern;
	logic [2*PAT_BYTES-1:0] scan_care;
	logic [LEN_W-1:0]       scan_length;

	// mirrored window (entry 0 newest) and segment byte count
	logic [7:0]  recent_bytes [PAT_BYTES];
	logic [31:0] segment_count;

	logic [31:0] expected_offsets [$];

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// nibble care mask of pattern byte k
	function automatic logic [7:0] care_of(input int k);
		return {{4{scan_care[2*k+1]}}, {4{scan_care[2*k]}}};
	endfunction

	// take one byte into the window and queue the offset of any match it completes
	task automatic scan_byte(input logic [7:0] b, input logic seg_start);
		int          i;
		int unsigned span;
		logic        hit;
		logic [7:0]  m;
		if (seg_start) begin
			for (i = 0; i < PAT_BYTES; i++)
				recent_bytes[i] = 8'h00;
			segment_count = 32'd0;
		end
		for (i = PAT_BYTES - 1; i > 0; i--)
			recent_bytes[i] = recent_bytes[i-1];
		recent_bytes[0] = b;
		if (segment_count != COUNT_MAX)
			segment_count++;

		span = (scan_length > PAT_BYTES) ? PAT_BYTES : scan_length;
		if (span == 0 || segment_count < span)
			return;
		// pattern byte i lines up with the byte seen span-1-i steps ago
		hit = 1'b1;
		for (i = 0; i < span; i++) begin
			m = care_of(i);
			if ((recent_bytes[span-1-i] & m) != (scan_pattern[8*i +: 8] & m))
				hit = 1'b0;
		end
		if (hit)
			expected_offsets.insert(expected_offsets.size(), segment_count - span);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			scan_pattern    = '0;
			scan_care       = '0;
			scan_length     = LEN_W'(1);
			for (int i = 0; i < PAT_BYTES; i++)
				recent_bytes[i] = 8'h00;
			segment_count   = 32'd0;
			expected_offsets.delete();
			fail_count      = 0;
			pending         = 0;
			bytes_scanned   = 0;
			matches_checked = 0;
		end else begin
			// a result leaves only after its byte has been taken in, so check before predicting
			if (m_tvalid && m_tready) begin
				if (expected_offsets.size() == 0) begin
					report_mismatch($sformatf("unexpected match, offset %0d", m_tdata));
				end else begin
					want = expected_offsets.pop_front();
					matches_checked++;
					if (m_tdata !== want)
						report_mismatch($sformatf("match_offset %0d, expected %0d",
							m_tdata, want));
				end
			end

			// register mirror; unknown indexes are dropped
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_PAT_A:  scan_pattern[63:0]    = pwdata;
					REG_PAT_B:  scan_pattern[127:64]  = pwdata;
					REG_PAT_C:  scan_pattern[191:128] = pwdata;
					REG_PAT_D:  scan_pattern[255:192] = pwdata;
					REG_CARE:   scan_care             = pwdata;
					REG_LENGTH: scan_length           = pwdata[LEN_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata, s_tuser);
				bytes_scanned++;
			end
			pending = expected_offsets.size();
		end
	end

endmodule

FILE: test/masked_byte_pattern_scanner_tb.sv
// Testbench top for the masked byte pattern scanner: clock, reset, APB setup,
// byte stream and result backpressure. Checking lives in
// masked_byte_pattern_scanner_checker; types come from mbps_pkg.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_tb;
	import mbps_pkg::*;

	localparam int RANDOM_BYTES  = 1650;
	localparam int NUM_SETTINGS  = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [63:0]       pwdata;
	logic [63:0]       prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] data_byte
	logic              s_tuser;   // [0] segment_start
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;   // [31:0] match_offset

	int fail_count;
	int pending;
	int bytes_scanned;
	int matches_checked;

	int          send_idle_pct;
	int          recv_idle_pct;
	logic        hold_armed;
	int          random_sent;
	int          cycle_count;

	// stimulus copy of the current scan settings
	logic [PAT_BYTES*8-1:0] gen_pattern;
	logic [2*PAT_BYTES-1:0] gen_care;
	int                     gen_span;

	masked_byte_pattern_scanner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	masked_byte_pattern_scanner_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending         (pending),
		.bytes_scanned   (bytes_scanned),
		.matches_checked (matches_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("masked_byte_pattern_scanner verification failed");
		$finish;
	end

	// result side: random stalls plus one long hold-off once armed
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// called at a falling edge; returns at the falling edge after the access
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// one byte request, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic seg_start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = seg_start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop the stream and let every result drain, plus pipeline slack
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_scan(input logic [PAT_BYTES*8-1:0] pat,
	                         input logic [2*PAT_BYTES-1:0] care,
	                         input logic [LEN_W-1:0] len);
		drain();
		write_reg(REG_PAT_A, pat[63:0]);
		write_reg(REG_PAT_B, pat[127:64]);
		write_reg(REG_PAT_C, pat[191:128]);
		write_reg(REG_PAT_D, pat[255:192]);
		write_reg(REG_CARE, care);
		write_reg(REG_LENGTH, {{(64-LEN_W){1'b0}}, len});
		// writes to unused indexes must change nothing
		write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
		gen_pattern = pat;
		gen_care    = care;
		gen_span    = (len > PAT_BYTES) ? PAT_BYTES : len;
	endtask

	function automatic logic [PAT_BYTES*8-1:0] random_pattern();
		logic [PAT_BYTES*8-1:0] p;
		for (int i = 0; i < PAT_BYTES / 4; i++)
			p[32*i +: 32] = $urandom;
		return p;
	endfunction

	// settings sweep: lengths 1, 32, 0, 63, all-care, all-wildcard, solid patterns
	task automatic choose_scan(input int sel);
		logic [PAT_BYTES*8-1:0] pat;
		logic [2*PAT_BYTES-1:0] care;
		logic [LEN_W-1:0]       len;
		pat  = random_pattern();
		care = {$urandom, $urandom};
		len  = LEN_W'($urandom_range(1, 8));
		case (sel)
			0: begin
				care = '1;
				len  = LEN_W'(1);
			end
			1: begin
				care = '1;
				len  = LEN_W'(32);
			end
			2: len = '0;
			3: len = '1;
			4: pat = '1;
			5: begin
				pat  = '0;
				care = '1;
			end
			8: begin
				care = '0;
				len  = LEN_W'($urandom_range(1, 32));
			end
			default: ;
		endcase
		load_scan(pat, care, len);
	endtask

	function automatic void set_idling();
		if (random_sent < RANDOM_BYTES / 3) begin
			send_idle_pct = 38;
			recv_idle_pct = 70;
		end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
			send_idle_pct = 70;
			recv_idle_pct = 38;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endfunction

	// mostly pattern occurrences with random wildcard content, some broken, some noise
	task automatic random_stream(input int count);
		int         sent;
		int         r;
		int         broken_at;
		int         bit_sel;
		logic [7:0] m;
		logic [7:0] b;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (gen_span != 0 && r < 60) begin
				broken_at = (r >= 45) ? $urandom_range(gen_span - 1) : -1;
				for (int k = 0; k < gen_span; k++) begin
					m = {{4{gen_care[2*k+1]}}, {4{gen_care[2*k]}}};
					b = (gen_pattern[8*k +: 8] & m) | (8'($urandom) & ~m);
					if (k == broken_at && m != 8'h00) begin
						do bit_sel = $urandom_range(7); while (!m[bit_sel]);
						b[bit_sel] = ~b[bit_sel];
					end
					set_idling();
					send_byte(b, (k == 0) && ($urandom_range(9) == 0));
					random_sent++;
				end
				sent += gen_span;
			end else begin
				set_idling();
				send_byte(8'($urandom), $urandom_range(19) == 0);
				random_sent++;
				sent++;
			end
		end
	endtask

	initial begin
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		s_tuser       = 1'b0;
		hold_armed    = 1'b0;
		random_sent   = 0;
		send_idle_pct = 38;
		recv_idle_pct = 70;
		arst_n        = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: one all-wildcard byte, so every byte matches;
		// the first bytes form a segment begun by reset
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h3C, 1'b1);
		send_byte(8'hC3, 1'b0);

		// 12 3? ?6 12 with junk pattern bits under the wildcards
		load_scan({192'd0, 64'h0000_0000_12A6_3F12}, 64'h0000_0000_0000_00DB, LEN_W'(4));
		send_byte(8'h12, 1'b1);
		send_byte(8'h30, 1'b0);
		send_byte(8'hF6, 1'b0);
		send_byte(8'h12, 1'b0);
		// overlapping second match sharing the last byte
		send_byte(8'h3E, 1'b0);
		send_byte(8'h06, 1'b0);
		send_byte(8'h12, 1'b0);
		// cared high nibble wrong
		send_byte(8'h20, 1'b0);
		send_byte(8'h06, 1'b0);
		send_byte(8'h12, 1'b0);
		// new segment restarts the offset
		send_byte(8'h12, 1'b1);
		send_byte(8'h3A, 1'b0);
		send_byte(8'h96, 1'b0);
		send_byte(8'h12, 1'b0);

		// all wildcards, length 3: nothing until the segment holds three bytes
		load_scan('0, '0, LEN_W'(3));
		send_byte(8'hAA, 1'b1);
		send_byte(8'hBB, 1'b0);
		send_byte(8'hCC, 1'b0);
		send_byte(8'hDD, 1'b0);

		for (int sel = 0; sel < NUM_SETTINGS; sel++) begin
			choose_scan(sel);
			// long result hold-off on the all-wildcard setting
			if (sel == 8)
				hold_armed = 1'b1;
			random_stream(RANDOM_BYTES / NUM_SETTINGS);
		end

		drain();
		repeat (10) @(negedge clk);
		$display("covered %0d bytes, %0d match offsets checked, over %0d pattern settings",
			bytes_scanned, matches_checked, NUM_SETTINGS + 2);
		$display("lengths 0 to 63, wildcard and solid masks, %0d-cycle result hold-off",
			HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("masked_byte_pattern_scanner verification clean");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("masked_byte_pattern_scanner verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/mbps_pkg.sv
rtl/mbps_cfg_regs.sv
rtl/mbps_window.sv
rtl/mbps_match.sv
rtl/masked_byte_pattern_scanner.sv
rtl/mbps_checker.sv
test/masked_byte_pattern_scanner_checker.sv
test/masked_byte_pattern_scanner_tb.sv
